>>> src/pkrs_pkg.sv
// Package with shared widths and operation codes for the preroll keyframe ring search.
`timescale 1ns / 1ps
`default_nettype none
package pkrs_pkg;

  localparam int STREAM_W = 8;
  localparam int PRE_W    = 8;
  localparam int START_W  = 8;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

endpackage
`default_nettype wire

>>> src/pkrs_in_if.sv
// Input channel carrying write and search words for the preroll keyframe ring search.
`timescale 1ns / 1ps
`default_nettype none
interface pkrs_in_if #(
  parameter int PTS_BITS = 48
);
  logic                              valid;
  logic                              ready;
  logic                              operation;
  logic [pkrs_pkg::STREAM_W-1:0]     entry_stream;
  logic signed [PTS_BITS-1:0]        entry_pts;
  logic                              entry_key;
  logic                              advance_head;
  logic [pkrs_pkg::STREAM_W-1:0]     stream_select;
  logic signed [PTS_BITS-1:0]        current_pts;
  logic [pkrs_pkg::PRE_W-1:0]        pre_count;

  modport source (
    output valid, operation, entry_stream, entry_pts, entry_key, advance_head,
           stream_select, current_pts, pre_count,
    input  ready
  );

  modport sink (
    input  valid, operation, entry_stream, entry_pts, entry_key, advance_head,
           stream_select, current_pts, pre_count,
    output ready
  );
endinterface
`default_nettype wire

>>> src/pkrs_out_if.sv
// Output channel carrying the start slot word of the preroll keyframe ring search.
`timescale 1ns / 1ps
`default_nettype none
interface pkrs_out_if;
  logic                           valid;
  logic                           ready;
  logic [pkrs_pkg::START_W-1:0]   start_index;

  modport source (
    output valid, start_index,
    input  ready
  );

  modport sink (
    input  valid, start_index,
    output ready
  );
endinterface
`default_nettype wire

>>> src/preroll_keyframe_ring_search.sv
// Sequence: a write word is simply accepted; a search word is accepted, the walk then examines
// ring records one by one (at most RING_DEPTH), and finally the output register is loaded.
// Throughput: one search at a time, bounded by the single ring memory read port that the
// walk sequencer uses once per cycle; writes are accepted back to back while idle.
// Reset clears the head pointer and the fill count, which marks every slot empty at once;
// no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module preroll_keyframe_ring_search #(
  parameter int RING_DEPTH = 256,
  parameter int PTS_BITS   = 48
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pkrs_in_if.sink   in_i,
  pkrs_out_if.source out_o
);

  localparam int IDX_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int FILL_W = IDX_W + 1;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(RING_DEPTH - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FIND  = 2'd1;
  localparam logic [1:0] ST_BACK  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  typedef struct packed {
    logic [pkrs_pkg::STREAM_W-1:0] stream;
    logic [PTS_BITS-1:0]           pts;
    logic                          key;
  } rec_t;

  function automatic logic [IDX_W-1:0] slot_prev(input logic [IDX_W-1:0] p);
    slot_prev = (p == '0) ? LAST_SLOT : p - IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] slot_next(input logic [IDX_W-1:0] p);
    slot_next = (p == LAST_SLOT) ? '0 : p + IDX_W'(1);
  endfunction

  rec_t ring_mem [RING_DEPTH];
  rec_t rd_data_q;
  logic [IDX_W-1:0] rd_addr;

  logic [1:0]                    state_q, state_d;
  logic [IDX_W-1:0]              head_q;
  logic [FILL_W-1:0]             fill_q;
  logic [IDX_W-1:0]              p_q, p_d;
  logic [pkrs_pkg::PRE_W-1:0]    cnt_q, cnt_d;
  logic [pkrs_pkg::STREAM_W-1:0] sel_q;
  logic signed [PTS_BITS-1:0]    cur_q;
  logic [IDX_W-1:0]              res_q, res_d;
  logic                          out_valid_q;
  logic [pkrs_pkg::START_W-1:0]  start_q;

  logic                          in_fire;
  logic                          wr_fire;
  logic                          srch_fire;
  logic                          slot_valid;
  logic                          stream_hit;
  logic                          pts_hit;
  logic [pkrs_pkg::PRE_W-1:0]    cnt_dec;
  logic [IDX_W+pkrs_pkg::START_W-1:0] res_ext;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign wr_fire    = in_fire && (in_i.operation == pkrs_pkg::OP_WRITE);
  assign srch_fire  = in_fire && (in_i.operation == pkrs_pkg::OP_SEARCH);

  assign rd_addr = (state_q == ST_IDLE) ? slot_prev(head_q) : slot_prev(p_q);

  always_ff @(posedge clk_i) begin
    if (wr_fire) begin
      ring_mem[head_q] <= '{stream: in_i.entry_stream, pts: in_i.entry_pts,
                            key: in_i.entry_key};
    end
    rd_data_q <= ring_mem[rd_addr];
  end

  assign slot_valid = ({1'b0, p_q} < fill_q);
  assign stream_hit = (rd_data_q.stream == sel_q);
  assign pts_hit    = ($signed(rd_data_q.pts) <= cur_q);
  assign cnt_dec    = (cnt_q != '0 && stream_hit) ? cnt_q - pkrs_pkg::PRE_W'(1) : cnt_q;

  always_comb begin
    state_d = state_q;
    p_d     = p_q;
    cnt_d   = cnt_q;
    res_d   = res_q;
    case (state_q)
      ST_IDLE: begin
        if (srch_fire) begin
          p_d     = slot_prev(head_q);
          cnt_d   = in_i.pre_count;
          state_d = ST_FIND;
        end
      end
      ST_FIND: begin
        if (!slot_valid) begin
          res_d   = slot_next(p_q);
          state_d = ST_DONE;
        end else if (stream_hit && pts_hit) begin
          if (cnt_q != '0 || !rd_data_q.key) begin
            p_d     = slot_prev(p_q);
            state_d = ST_BACK;
          end else begin
            res_d   = p_q;
            state_d = ST_DONE;
          end
        end else if (slot_prev(p_q) == head_q) begin
          res_d   = slot_next(head_q);
          state_d = ST_DONE;
        end else begin
          p_d = slot_prev(p_q);
        end
      end
      ST_BACK: begin
        if (!slot_valid || p_q == head_q) begin
          res_d   = slot_next(p_q);
          state_d = ST_DONE;
        end else if (cnt_dec == '0 && stream_hit && rd_data_q.key) begin
          res_d   = p_q;
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_dec;
          p_d   = slot_prev(p_q);
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_ext = {{pkrs_pkg::START_W{1'b0}}, res_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (wr_fire) begin
        if ({1'b0, head_q} == fill_q) begin
          fill_q <= fill_q + FILL_W'(1);
        end
        if (in_i.advance_head) begin
          head_q <= slot_next(head_q);
        end
      end
      if (state_q == ST_DONE && (!out_valid_q || out_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q   <= p_d;
    cnt_q <= cnt_d;
    res_q <= res_d;
    if (srch_fire) begin
      sel_q <= in_i.stream_select;
      cur_q <= in_i.current_pts;
    end
    if (state_q == ST_DONE && (!out_valid_q || out_o.ready)) begin
      start_q <= res_ext[pkrs_pkg::START_W-1:0];
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.start_index = start_q;

endmodule
`default_nettype wire

>>> tb/tb_preroll_keyframe_ring_search.sv
// Self-checking testbench for the preroll keyframe ring search: record writes and searches.
`timescale 1ns / 1ps
module tb_preroll_keyframe_ring_search;

  localparam int RING_DEPTH    = 256;
  localparam int PTS_BITS      = 48;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = RING_DEPTH + 8;

  localparam logic signed [PTS_BITS-1:0] PTS_MAX = {1'b0, {(PTS_BITS-1){1'b1}}};
  localparam logic signed [PTS_BITS-1:0] PTS_MIN = {1'b1, {(PTS_BITS-1){1'b0}}};

  logic clk;
  logic rst_n;

  pkrs_in_if #(.PTS_BITS(PTS_BITS)) word_in ();
  pkrs_out_if word_out ();

  preroll_keyframe_ring_search #(
    .RING_DEPTH(RING_DEPTH),
    .PTS_BITS  (PTS_BITS)
  ) i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (word_in),
    .out_o (word_out)
  );

  // Shadow copy of the ring and its head pointer.
  bit                                ring_valid  [RING_DEPTH];
  logic [pkrs_pkg::STREAM_W-1:0]     ring_stream [RING_DEPTH];
  logic signed [PTS_BITS-1:0]        ring_pts    [RING_DEPTH];
  logic                              ring_key    [RING_DEPTH];
  int unsigned                       head_slot;

  logic [pkrs_pkg::START_W-1:0] expected_start_q[$];

  bit          idle_en;
  bit          stall_en;
  int unsigned error_count;
  int unsigned write_count;
  int unsigned search_count;
  int unsigned checked_count;
  int unsigned wrap_count;
  int unsigned cycle_count;
  logic signed [PTS_BITS-1:0] pts_clock;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned prev_slot(input int unsigned p);
    return (p == 0) ? RING_DEPTH - 1 : p - 1;
  endfunction

  function automatic int unsigned next_slot(input int unsigned p);
    return (p + 1 >= RING_DEPTH) ? 0 : p + 1;
  endfunction

  function automatic logic signed [PTS_BITS-1:0] random_pts();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[PTS_BITS-1:0];
  endfunction

  function automatic logic [pkrs_pkg::START_W-1:0] find_start_slot(
    input logic [pkrs_pkg::STREAM_W-1:0] sel,
    input logic signed [PTS_BITS-1:0]    cur,
    input logic [pkrs_pkg::PRE_W-1:0]    pre
  );
    int unsigned p;
    int          remaining;
    p = prev_slot(head_slot);
    while (1) begin
      if (!ring_valid[p]) return pkrs_pkg::START_W'(next_slot(p));
      if (ring_stream[p] == sel && ring_pts[p] <= cur) break;
      p = prev_slot(p);
      if (p == head_slot) return pkrs_pkg::START_W'(next_slot(p));
    end
    remaining = int'(pre);
    while (remaining > 0 || !(ring_stream[p] == sel && ring_key[p])) begin
      p = prev_slot(p);
      if (!ring_valid[p]) return pkrs_pkg::START_W'(next_slot(p));
      if (ring_stream[p] == sel) remaining--;
      if (p == head_slot) return pkrs_pkg::START_W'(next_slot(p));
    end
    return pkrs_pkg::START_W'(p);
  endfunction

  task automatic send_word(
    input logic                          op,
    input logic [pkrs_pkg::STREAM_W-1:0] stream,
    input logic signed [PTS_BITS-1:0]    pts,
    input logic                          key,
    input logic                          adv,
    input logic [pkrs_pkg::STREAM_W-1:0] sel,
    input logic signed [PTS_BITS-1:0]    cur,
    input logic [pkrs_pkg::PRE_W-1:0]    pre
  );
    if (idle_en && $urandom_range(0, 4) == 0) begin
      word_in.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    word_in.valid         <= 1'b1;
    word_in.operation     <= op;
    word_in.entry_stream  <= stream;
    word_in.entry_pts     <= pts;
    word_in.entry_key     <= key;
    word_in.advance_head  <= adv;
    word_in.stream_select <= sel;
    word_in.current_pts   <= cur;
    word_in.pre_count     <= pre;
    do @(posedge clk); while (!word_in.ready);
    if (op == pkrs_pkg::OP_WRITE) begin
      ring_valid[head_slot]  = 1'b1;
      ring_stream[head_slot] = stream;
      ring_pts[head_slot]    = pts;
      ring_key[head_slot]    = key;
      if (adv) begin
        head_slot = next_slot(head_slot);
        if (head_slot == 0) wrap_count++;
      end
      write_count++;
    end else begin
      expected_start_q.push_back(find_start_slot(sel, cur, pre));
      search_count++;
    end
  endtask

  // Fields that the operation ignores carry random values.
  task automatic write_record(
    input logic [pkrs_pkg::STREAM_W-1:0] stream,
    input logic signed [PTS_BITS-1:0]    pts,
    input logic                          key,
    input logic                          adv
  );
    send_word(pkrs_pkg::OP_WRITE, stream, pts, key, adv,
              pkrs_pkg::STREAM_W'($urandom()), random_pts(),
              pkrs_pkg::PRE_W'($urandom()));
  endtask

  task automatic search_start(
    input logic [pkrs_pkg::STREAM_W-1:0] sel,
    input logic signed [PTS_BITS-1:0]    cur,
    input logic [pkrs_pkg::PRE_W-1:0]    pre
  );
    send_word(pkrs_pkg::OP_SEARCH, pkrs_pkg::STREAM_W'($urandom()), random_pts(),
              1'($urandom()), 1'($urandom()), sel, cur, pre);
  endtask

  task automatic test_empty_ring();
    search_start(8'd0, PTS_MAX, 8'd0);
    search_start(8'd255, PTS_MIN, 8'd255);
  endtask

  task automatic test_directed_cases();
    write_record(8'd1, PTS_MIN, 1'b1, 1'b1);
    write_record(8'd1, -48'sd5, 1'b0, 1'b1);
    write_record(8'd255, PTS_MAX, 1'b1, 1'b1);
    write_record(8'd1, 48'sd10, 1'b1, 1'b0);
    write_record(8'd1, 48'sd12, 1'b0, 1'b1);
    write_record(8'd0, 48'sd20, 1'b1, 1'b1);
    write_record(8'd1, 48'sd30, 1'b0, 1'b1);
    search_start(8'd1, PTS_MAX, 8'd0);
    search_start(8'd1, 48'sd0, 8'd0);
    search_start(8'd1, PTS_MIN, 8'd0);
    search_start(8'd0, 48'sd19, 8'd0);
    search_start(8'd0, 48'sd20, 8'd0);
    search_start(8'd0, 48'sd20, 8'd1);
    search_start(8'd1, 48'sd30, 8'd2);
    search_start(8'd255, PTS_MAX, 8'd255);
    search_start(8'd255, PTS_MIN, 8'd0);
  endtask

  // Mostly a few streams with rising timestamps, so searches find matches and keys.
  task automatic test_random_traffic(input int unsigned n);
    logic [pkrs_pkg::STREAM_W-1:0] stream;
    logic signed [PTS_BITS-1:0]    pts;
    logic signed [PTS_BITS-1:0]    cur;
    logic [pkrs_pkg::PRE_W-1:0]    pre;
    int unsigned                   pick;
    repeat (n) begin
      stream = ($urandom_range(0, 9) < 8) ? pkrs_pkg::STREAM_W'($urandom_range(0, 3))
                                          : pkrs_pkg::STREAM_W'($urandom());
      if ($urandom_range(0, 99) < 85) begin
        pts_clock = pts_clock + PTS_BITS'($urandom_range(0, 40));
        pick = $urandom_range(0, 99);
        pts = (pick < 85) ? pts_clock - PTS_BITS'($urandom_range(0, 20)) : random_pts();
        write_record(stream, pts, ($urandom_range(0, 9) < 3), ($urandom_range(0, 9) != 0));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70) cur = pts_clock - PTS_BITS'($urandom_range(0, 300));
        else if (pick < 85) cur = random_pts();
        else cur = $urandom_range(0, 1) ? PTS_MAX : PTS_MIN;
        pick = $urandom_range(0, 99);
        if (pick < 70) pre = pkrs_pkg::PRE_W'($urandom_range(0, 3));
        else if (pick < 90) pre = pkrs_pkg::PRE_W'($urandom_range(4, 20));
        else pre = pkrs_pkg::PRE_W'($urandom());
        search_start(stream, cur, pre);
      end
    end
  endtask

  initial begin
    word_out.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (stall_en && $urandom_range(0, 5) == 0) begin
        word_out.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      word_out.ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && word_out.valid && word_out.ready) begin
      if (expected_start_q.size() == 0) begin
        $display("%0t: start_index %0d arrived with no search pending", $time,
                 word_out.start_index);
        error_count++;
      end else begin
        if (word_out.start_index !== expected_start_q[0]) begin
          $display("%0t: start_index mismatch, expected %0d, actual %0d", $time,
                   expected_start_q[0], word_out.start_index);
          error_count++;
        end
        void'(expected_start_q.pop_front());
        checked_count++;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run stopped at the cycle limit with %0d start slots outstanding.",
             expected_start_q.size());
    $display("FAIL");
    $finish;
  end

  initial begin
    rst_n                 <= 1'b0;
    word_in.valid         <= 1'b0;
    word_in.operation     <= pkrs_pkg::OP_WRITE;
    word_in.entry_stream  <= '0;
    word_in.entry_pts     <= '0;
    word_in.entry_key     <= 1'b0;
    word_in.advance_head  <= 1'b0;
    word_in.stream_select <= '0;
    word_in.current_pts   <= '0;
    word_in.pre_count     <= '0;
    head_slot     = 0;
    error_count   = 0;
    write_count   = 0;
    search_count  = 0;
    checked_count = 0;
    wrap_count    = 0;
    pts_clock     = -48'sd3000;
    idle_en       = 1'b1;
    stall_en      = 1'b1;
    foreach (ring_valid[i]) ring_valid[i] = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_ring();
    test_directed_cases();
    test_random_traffic(750);
    idle_en  = 1'b0;
    stall_en = 1'b0;
    test_random_traffic(150);
    word_in.valid <= 1'b0;

    while (expected_start_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d record writes and %0d searches; %0d start slots compared.",
             write_count, search_count, checked_count);
    $display("The head wrapped %0d times; %0d mismatches were seen.", wrap_count, error_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
